// ===== src/indexed_list_engine_top_assert.svh =====
// Assertion macros used by the list engine port checker
`ifndef INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
// same-cycle implication, clocked on clock and held off during reset
`define ILE_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, clocked on clock and held off during reset
`define ILE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== src/ile_pkg.sv =====
// Shared types and codes for the indexed list engine
package ile_pkg;

   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int LEN_OUT_W = 7;
   localparam int SPAN_W   = 7;

   typedef enum logic [2:0] {
      OP_APPEND       = 3'd0,
      OP_INSERT       = 3'd1,
      OP_REMOVE       = 3'd2,
      OP_REMOVE_RANGE = 3'd3,
      OP_GET          = 3'd4,
      OP_SET          = 3'd5,
      OP_SEARCH       = 3'd6,
      OP_CLEAR        = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_BADPOS   = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EXEC,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_INSERT,
      CM_SHIFT_DN,
      CM_WRITE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type            mode;
      logic signed [VAL_W-1:0]  value;
   } cell_cmd_type;

endpackage

// ===== src/indexed_list_engine_top.sv =====
// Indexed list engine: top level joining the sequencer and the row of entry cells
//
// Requests arrive on the req_ channel (valid/ready) and each one yields exactly
// one rsp_ beat carrying status, data, first and last match and the new length.
// Every entry lives in its own cell; insert and remove move entries one place
// per cycle between neighbouring cells, get/set/search look at all cells at once.
// Each request passes through the LOOK and EXEC states to DONE, which loads the
// output register; remove range shifts down once more in SHIFT per extra entry.
// A request is taken only while the sequencer is idle, so a new request waits
// until the previous one has passed through its states back to idle.
// The response sits in an output register, so the next request is taken while
// an earlier response still waits; if the receiver stalls, a finished result
// waits in the sequencer until the output register frees up.
// Synchronous reset empties the list (length zero) and drops any pending
// response; entry contents are left as they are and are never read unwritten.
module indexed_list_engine_top import ile_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic [POS_W-1:0]        req_position,
   input  logic [POS_W-1:0]        req_end_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_data,
   output logic [POS_W-1:0]        rsp_first_match_res,
   output logic [POS_W-1:0]        rsp_last_match,
   output logic [LEN_OUT_W-1:0]    rsp_length
);

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);

   cell_cmd_type            cell_cmd;
   logic [IW-1:0]           cell_at;
   logic signed [VAL_W-1:0] cell_data [CAPACITY];
   logic signed [VAL_W-1:0] cell_tap [CAPACITY];
   logic [CAPACITY-1:0]     cell_hit;

   ile_ctrl #(
      .CAPACITY (CAPACITY),
      .IW       (IW),
      .LW       (LW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_end_position    (req_end_position),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_data            (rsp_data),
      .rsp_first_match_res (rsp_first_match_res),
      .rsp_last_match      (rsp_last_match),
      .rsp_length          (rsp_length),
      .cmd_out             (cell_cmd),
      .at_out              (cell_at),
      .tap_in              (cell_tap),
      .hit_in              (cell_hit)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_w;
      logic signed [VAL_W-1:0] right_w;

      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = cell_data[g+1];
      end

      ile_cell #(
         .IW  (IW),
         .IDX (g)
      ) u_cell (
         .clock    (clock),
         .cmd      (cell_cmd),
         .at       (cell_at),
         .left_in  (left_w),
         .right_in (right_w),
         .data_out (cell_data[g]),
         .tap_out  (cell_tap[g]),
         .hit_out  (cell_hit[g])
      );
   end

endmodule

// ===== src/ile_cell.sv =====
// One list entry: holds a value, shifts with its neighbours, offers read tap and match
module ile_cell import ile_pkg::*; #(
   parameter int IW  = 6,
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic [IW-1:0]           at,
   input  logic signed [VAL_W-1:0] left_in,
   input  logic signed [VAL_W-1:0] right_in,
   output logic signed [VAL_W-1:0] data_out,
   output logic signed [VAL_W-1:0] tap_out,
   output logic                    hit_out
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic signed [VAL_W-1:0] data_ff, data_in;
   logic signed [VAL_W-1:0] tap_ff, tap_in;
   logic                    hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.mode)
         CM_INSERT: begin
            if (MY_IDX > at) begin
               data_in = left_in;
            end else if (MY_IDX == at) begin
               data_in = cmd.value;
            end
         end
         CM_SHIFT_DN: begin
            if (MY_IDX >= at) begin
               data_in = right_in;
            end
         end
         CM_WRITE: begin
            if (MY_IDX == at) begin
               data_in = cmd.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
      tap_in = (MY_IDX == at) ? data_ff : '0;
      hit_in = (data_ff == cmd.value);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
      hit_ff  <= hit_in;
   end

   assign data_out = data_ff;
   assign tap_out  = tap_ff;
   assign hit_out  = hit_ff;

endmodule

// ===== src/ile_ctrl.sv =====
// Sequencer: request decode, length, result build and output register
module ile_ctrl import ile_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int IW       = 6,
   parameter int LW       = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic [POS_W-1:0]        req_position,
   input  logic [POS_W-1:0]        req_end_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_data,
   output logic [POS_W-1:0]        rsp_first_match_res,
   output logic [POS_W-1:0]        rsp_last_match,
   output logic [LEN_OUT_W-1:0]    rsp_length,
   output cell_cmd_type            cmd_out,
   output logic [IW-1:0]           at_out,
   input  logic signed [VAL_W-1:0] tap_in [CAPACITY],
   input  logic [CAPACITY-1:0]     hit_in
);

   localparam int CW = (LW > POS_W) ? LW : POS_W;
   localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

   state_type               state_ff, state_in;
   logic [LW-1:0]           len_ff, len_in;
   opcode_type              op_ff, op_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        endp_ff, endp_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [SPAN_W-1:0]       cnt_ff, cnt_in;
   status_type              res_status_ff, res_status_in;
   logic signed [VAL_W-1:0] res_data_ff, res_data_in;
   logic [POS_W-1:0]        res_first_ff, res_first_in;
   logic [POS_W-1:0]        res_last_ff, res_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]        rsp_first_ff, rsp_first_in;
   logic [POS_W-1:0]        rsp_last_ff, rsp_last_in;
   logic [LEN_OUT_W-1:0]    rsp_length_ff, rsp_length_in;

   logic signed [VAL_W-1:0] tap_data;
   logic [CAPACITY-1:0]     hit_mask;
   logic [IW-1:0]           first_idx;
   logic [IW-1:0]           last_idx;
   logic [CW-1:0]           pos_c;
   logic [CW-1:0]           endp_c;
   logic [CW-1:0]           len_c;
   logic [SPAN_W-1:0]       span;

   // read tap reduction, valid-length mask and match encoders
   always_comb begin
      tap_data  = '0;
      first_idx = '0;
      last_idx  = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         tap_data    = tap_data | tap_in[k];
         hit_mask[k] = hit_in[k] && (LW'(k) < len_ff);
      end
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (hit_mask[k]) begin
            first_idx = IW'(k);
         end
      end
      for (int k = 0; k < CAPACITY; k++) begin
         if (hit_mask[k]) begin
            last_idx = IW'(k);
         end
      end
   end

   assign pos_c  = CW'(pos_ff);
   assign endp_c = CW'(endp_ff);
   assign len_c  = CW'(len_ff);
   assign span   = SPAN_W'(endp_ff) - SPAN_W'(pos_ff) + SPAN_W'(1);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      endp_in       = endp_ff;
      value_in      = value_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_first_in  = res_first_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;
      cmd_out.mode  = CM_HOLD;
      cmd_out.value = value_ff;
      at_out        = IW'(pos_ff);
      req_ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               pos_in   = req_position;
               endp_in  = req_end_position;
               value_in = req_value;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_data_in   = '0;
            res_first_in  = '0;
            res_last_in   = '0;
            state_in      = ST_DONE;
            case (op_ff)
               OP_APPEND: begin
                  if (len_ff >= CAP_L) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     cmd_out.mode = CM_INSERT;
                     at_out       = IW'(len_ff);
                     len_in       = len_ff + LW'(1);
                  end
               end
               OP_INSERT: begin
                  if (pos_c > len_c) begin
                     res_status_in = STAT_BADPOS;
                  end else if (len_ff >= CAP_L) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     cmd_out.mode = CM_INSERT;
                     len_in       = len_ff + LW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else if (pos_c >= len_c) begin
                     res_status_in = STAT_BADPOS;
                  end else begin
                     res_data_in  = tap_data;
                     cmd_out.mode = CM_SHIFT_DN;
                     len_in       = len_ff - LW'(1);
                  end
               end
               OP_REMOVE_RANGE: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else if (pos_c > endp_c || endp_c >= len_c) begin
                     res_status_in = STAT_BADPOS;
                  end else begin
                     cmd_out.mode = CM_SHIFT_DN;
                     len_in       = len_ff - LW'(span);
                     cnt_in       = span - SPAN_W'(1);
                     if (span != SPAN_W'(1)) begin
                        state_in = ST_SHIFT;
                     end
                  end
               end
               OP_GET: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else if (pos_c >= len_c) begin
                     res_status_in = STAT_BADPOS;
                  end else begin
                     res_data_in = tap_data;
                  end
               end
               OP_SET: begin
                  if (len_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                  end else if (pos_c >= len_c) begin
                     res_status_in = STAT_BADPOS;
                  end else begin
                     res_data_in  = tap_data;
                     cmd_out.mode = CM_WRITE;
                  end
               end
               OP_SEARCH: begin
                  if (hit_mask == '0) begin
                     res_status_in = STAT_NOTFOUND;
                  end else begin
                     res_first_in = POS_W'(first_idx);
                     res_last_in  = POS_W'(last_idx);
                  end
               end
               OP_CLEAR: begin
                  len_in = '0;
               end
               default: begin
                  len_in = '0;
               end
            endcase
         end
         ST_SHIFT: begin
            cmd_out.mode = CM_SHIFT_DN;
            cnt_in       = cnt_ff - SPAN_W'(1);
            if (cnt_ff == SPAN_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_first_in  = res_first_ff;
               rsp_last_in   = res_last_ff;
               rsp_length_in = LEN_OUT_W'(len_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      endp_ff       <= endp_in;
      value_ff      <= value_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_first_ff  <= res_first_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_data            = rsp_data_ff;
   assign rsp_first_match_res = rsp_first_ff;
   assign rsp_last_match      = rsp_last_ff;
   assign rsp_length          = rsp_length_ff;

endmodule

// ===== src/ile_checker.sv =====
// Port-level checks for the indexed list engine, bound to the top level
`include "indexed_list_engine_top_assert.svh"

module ile_checker import ile_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [2:0]              rsp_status,
   input logic signed [VAL_W-1:0] rsp_data,
   input logic [POS_W-1:0]        rsp_first_match_res,
   input logic [POS_W-1:0]        rsp_last_match,
   input logic [LEN_OUT_W-1:0]    rsp_length
);

   `ILE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_status), "response beat changed while stalled")
   `ILE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second request taken straight after a beat")
   `ILE_ASSERT_SAME(a_err_no_data, rsp_valid && rsp_status != STAT_OK, rsp_data == '0, "error response carries data")
   `ILE_ASSERT_SAME(a_empty_len, rsp_valid && rsp_status == STAT_EMPTY, rsp_length == '0, "empty status with non-zero length")
   `ILE_ASSERT_SAME(a_nomatch_zero, rsp_valid && rsp_status == STAT_NOTFOUND, rsp_first_match_res == '0 && rsp_last_match == '0, "match fields set without a match")

endmodule

bind indexed_list_engine_top ile_checker u_checker (.*);

// ===== test/list_checker.sv =====
// Checker for the indexed list engine: tracks the list, predicts each response and compares
module list_checker import ile_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic [POS_W-1:0]        req_position,
   input  logic [POS_W-1:0]        req_end_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [2:0]              rsp_status,
   input  logic signed [VAL_W-1:0] rsp_data,
   input  logic [POS_W-1:0]        rsp_first_match_res,
   input  logic [POS_W-1:0]        rsp_last_match,
   input  logic [LEN_OUT_W-1:0]    rsp_length,
   output int                      fail_count,
   output int                      outstanding,
   output int                      list_len
);

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] data;
      logic [POS_W-1:0]        first_pos;
      logic [POS_W-1:0]        last_pos;
      logic [LEN_OUT_W-1:0]    length;
   } list_answer_type;

   logic signed [VAL_W-1:0] entries [CAPACITY];
   int unsigned             entry_count;
   list_answer_type         answers_due [$];

   function automatic void close_gap(input int unsigned lo, input int unsigned span);
      int unsigned k;
      for (k = lo; k + span < entry_count; k++)
         entries[k] = entries[k + span];
      entry_count -= span;
   endfunction

   function automatic list_answer_type apply_list_op(input opcode_type op, input int unsigned pos,
         input int unsigned endp, input logic signed [VAL_W-1:0] val);
      list_answer_type ans;
      int unsigned     k;
      bit              hit;
      ans = '0;
      ans.status = STAT_OK;
      hit = 1'b0;
      case (op)
         OP_APPEND: begin
            if (entry_count >= CAPACITY) begin
               ans.status = STAT_FULL;
            end else begin
               entries[entry_count] = val;
               entry_count++;
            end
         end
         OP_INSERT: begin
            if (pos > entry_count) begin
               ans.status = STAT_BADPOS;
            end else if (entry_count >= CAPACITY) begin
               ans.status = STAT_FULL;
            end else begin
               for (k = entry_count; k > pos; k--)
                  entries[k] = entries[k - 1];
               entries[pos] = val;
               entry_count++;
            end
         end
         OP_REMOVE, OP_GET, OP_SET: begin
            if (entry_count == 0) begin
               ans.status = STAT_EMPTY;
            end else if (pos >= entry_count) begin
               ans.status = STAT_BADPOS;
            end else begin
               ans.data = entries[pos];
               if (op == OP_REMOVE)
                  close_gap(pos, 1);
               else if (op == OP_SET)
                  entries[pos] = val;
            end
         end
         OP_REMOVE_RANGE: begin
            if (entry_count == 0)
               ans.status = STAT_EMPTY;
            else if (pos > endp || endp >= entry_count)
               ans.status = STAT_BADPOS;
            else
               close_gap(pos, endp - pos + 1);
         end
         OP_SEARCH: begin
            for (k = 0; k < entry_count; k++) begin
               if (entries[k] == val) begin
                  if (!hit)
                     ans.first_pos = k[POS_W-1:0];
                  ans.last_pos = k[POS_W-1:0];
                  hit = 1'b1;
               end
            end
            if (!hit)
               ans.status = STAT_NOTFOUND;
         end
         default: begin
            entry_count = 0;
         end
      endcase
      ans.length = entry_count[LEN_OUT_W-1:0];
      return ans;
   endfunction

   function automatic void note_mismatch(input string field, input longint want,
         input longint got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      list_answer_type due;
      if (reset) begin
         entry_count = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with nothing expected, expected none, got status %0d",
                        $time, rsp_status);
            end else begin
               due = answers_due.pop_front();
               if (rsp_status != due.status)
                  note_mismatch("status", due.status, rsp_status);
               if (rsp_data != due.data)
                  note_mismatch("data", due.data, rsp_data);
               if (rsp_first_match_res != due.first_pos)
                  note_mismatch("first match", due.first_pos, rsp_first_match_res);
               if (rsp_last_match != due.last_pos)
                  note_mismatch("last match", due.last_pos, rsp_last_match);
               if (rsp_length != due.length)
                  note_mismatch("length", due.length, rsp_length);
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(apply_list_op(opcode_type'(req_opcode), req_position,
                                                req_end_position, req_value));
      end
      outstanding <= answers_due.size();
      list_len    <= entry_count;
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the indexed list engine: clock, reset, stimulus and verdict
module tb_top;
   import ile_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_START   = 1500;
   localparam int HOLD_CYCLES  = 120;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [2:0]              req_opcode;
   logic [POS_W-1:0]        req_position;
   logic [POS_W-1:0]        req_end_position;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [2:0]              rsp_status;
   logic signed [VAL_W-1:0] rsp_data;
   logic [POS_W-1:0]        rsp_first_match_res;
   logic [POS_W-1:0]        rsp_last_match;
   logic [LEN_OUT_W-1:0]    rsp_length;

   int fail_count;
   int outstanding;
   int list_len;
   int cycle_count;
   bit sender_quiet;
   bit filling;

   indexed_list_engine_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_end_position    (req_end_position),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_data            (rsp_data),
      .rsp_first_match_res (rsp_first_match_res),
      .rsp_last_match      (rsp_last_match),
      .rsp_length          (rsp_length)
   );

   list_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_end_position    (req_end_position),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_data            (rsp_data),
      .rsp_first_match_res (rsp_first_match_res),
      .rsp_last_match      (rsp_last_match),
      .rsp_length          (rsp_length),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .list_len            (list_len)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

   // receiver: random back-pressure, one long hold-off, one stretch always ready
   initial begin
      int rx_cycles;
      rx_cycles = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycles++;
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (rx_cycles >= 3000 && rx_cycles < 3600)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 35);
      end
   end

   task automatic offer_request(input opcode_type op, input int unsigned pos,
         input int unsigned endp, input logic signed [VAL_W-1:0] val);
      while (!sender_quiet && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_position     <= pos[POS_W-1:0];
      req_end_position <= endp[POS_W-1:0];
      req_value        <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] pool [8];
      pool = '{0, -1, 1, 32'sh8000_0000, 32'sh7fff_ffff, 5, 42, -42};
      if ($urandom_range(1) == 0)
         return pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic random_request();
      int unsigned len;
      int unsigned r;
      int unsigned pos;
      int unsigned endp;
      opcode_type  op;
      len = list_len;
      if (len >= 64)
         filling = 1'b0;
      else if (len == 0)
         filling = 1'b1;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 38)      op = OP_APPEND;
         else if (r < 65) op = OP_INSERT;
         else if (r < 70) op = OP_REMOVE;
         else if (r < 72) op = OP_REMOVE_RANGE;
         else if (r < 82) op = OP_GET;
         else if (r < 90) op = OP_SET;
         else             op = OP_SEARCH;
      end else begin
         if (r < 5)       op = OP_APPEND;
         else if (r < 10) op = OP_INSERT;
         else if (r < 45) op = OP_REMOVE;
         else if (r < 55) op = OP_REMOVE_RANGE;
         else if (r < 67) op = OP_GET;
         else if (r < 77) op = OP_SET;
         else if (r < 97) op = OP_SEARCH;
         else             op = OP_CLEAR;
      end
      if (op == OP_INSERT)
         pos = $urandom_range(0, (len > 63) ? 63 : len);
      else
         pos = (len == 0) ? 0 : $urandom_range(0, len - 1);
      if ($urandom_range(9) == 0)
         pos = $urandom_range(0, 63);
      endp = pos + $urandom_range(0, 3);
      if (endp > 63)
         endp = 63;
      if ($urandom_range(9) == 0)
         endp = $urandom_range(0, 63);
      offer_request(op, pos, endp, pick_value());
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_APPEND;
      req_position     = '0;
      req_end_position = '0;
      req_value        = '0;
      sender_quiet     = 1'b0;
      filling          = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list
      offer_request(OP_GET, 0, 0, 0);
      offer_request(OP_REMOVE, 0, 0, 0);
      offer_request(OP_REMOVE_RANGE, 0, 0, 0);
      offer_request(OP_SET, 0, 0, 7);
      offer_request(OP_SEARCH, 0, 0, 0);
      offer_request(OP_INSERT, 1, 0, 3);
      offer_request(OP_CLEAR, 0, 0, 0);
      // small list with extreme values
      offer_request(OP_APPEND, 0, 0, 32'sh8000_0000);
      offer_request(OP_APPEND, 0, 0, 32'sh7fff_ffff);
      offer_request(OP_INSERT, 0, 0, 0);
      offer_request(OP_INSERT, 3, 0, -1);
      offer_request(OP_INSERT, 63, 0, 1);
      offer_request(OP_GET, 63, 0, 0);
      offer_request(OP_GET, 3, 0, 0);
      offer_request(OP_SET, 1, 0, -1);
      offer_request(OP_SEARCH, 0, 0, -1);
      offer_request(OP_SEARCH, 0, 0, 12345);
      offer_request(OP_REMOVE, 4, 0, 0);
      offer_request(OP_REMOVE, 0, 0, 0);
      offer_request(OP_REMOVE_RANGE, 2, 1, 0);
      offer_request(OP_REMOVE_RANGE, 0, 3, 0);
      offer_request(OP_REMOVE_RANGE, 1, 2, 0);
      offer_request(OP_REMOVE_RANGE, 0, 0, 0);
      // full list: refused growth, whole-list range removal, clear when full
      repeat (64) offer_request(OP_APPEND, 0, 0, pick_value());
      offer_request(OP_APPEND, 0, 0, 9);
      offer_request(OP_INSERT, 63, 0, 9);
      offer_request(OP_INSERT, 0, 0, 9);
      offer_request(OP_GET, 63, 0, 0);
      offer_request(OP_SEARCH, 0, 0, 42);
      offer_request(OP_REMOVE_RANGE, 0, 63, 0);
      for (int n = 0; n < 64; n++)
         offer_request(OP_INSERT, $urandom_range(0, n), 0, pick_value());
      offer_request(OP_CLEAR, 0, 0, 0);
      wait_all_answered();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_quiet = (n >= 200 && n < 320);
         if (n == 400)
            wait_all_answered();
         random_request();
      end
      wait_all_answered();
      repeat (80) @(posedge clock);

      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== indexed_list_engine_top.f =====
+incdir+src
src/ile_pkg.sv
src/ile_cell.sv
src/ile_ctrl.sv
src/indexed_list_engine_top.sv
src/ile_checker.sv
test/list_checker.sv
test/tb_top.sv
